>>> hw/rtl/chunk_prefix_lru_cache_top_assert.svh
// ----------------------------------------------------------------------------
// chunk_prefix_lru_cache_top_assert.svh
// Assertion macros used by the cache index checker.
// ----------------------------------------------------------------------------
`ifndef CHUNK_PREFIX_LRU_CACHE_TOP_ASSERT_SVH
`define CHUNK_PREFIX_LRU_CACHE_TOP_ASSERT_SVH

// Clocked assertion, idle while reset is held
`define CLRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication
`define CLRU_IMPLIES(lbl, ante, cons, msg) \
    `CLRU_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define CLRU_NEXT(lbl, ante, cons, msg) \
    `CLRU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/clru_pkg.sv
// ----------------------------------------------------------------------------
// clru_pkg
// Types and constants of the chunk-prefix LRU cache index.
// ----------------------------------------------------------------------------
package clru_pkg;

    localparam int MAX_FILES_DEF = 64;

    // Field widths
    localparam int FILE_W  = 32;
    localparam int CHUNK_W = 16;
    localparam int ACC_W   = 17;
    localparam int LAT_W   = 32;
    localparam int TIME_W  = 20;
    localparam int BEATS_W = 11;
    localparam int FCAP_W  = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_PACKET_CAP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_CAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHUNK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_TIME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_TIME  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BEATS       = 3'd5;

    // Reset values of the registers
    localparam logic [CHUNK_W-1:0] RST_PACKET_CAP  = 16'd4096;
    localparam logic [FCAP_W-1:0]  RST_FILE_CAP    = 7'd64;
    localparam logic [CHUNK_W-1:0] RST_FIRST_CHUNK = 16'd0;
    localparam logic [TIME_W-1:0]  RST_FIRST_TIME  = 20'd1000;
    localparam logic [TIME_W-1:0]  RST_BURST_TIME  = 20'd1000;
    localparam logic [BEATS_W-1:0] RST_BEATS       = 11'd8;

    // Request codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_STORE  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [FILE_W-1:0]  file_id;
        logic [CHUNK_W-1:0] chunk_id;
    } in_word_t;

    typedef struct packed {
        logic             hit;
        logic             stored;
        logic [ACC_W-1:0] dram_accesses;
        logic [LAT_W-1:0] latency;
    } out_word_t;

endpackage

>>> hw/rtl/clru_cost.sv
// ----------------------------------------------------------------------------
// clru_cost
// Cost unit: lat = first + (beats-1)*burst + (acc-1)*first, modulo 2^32, on one
// shared multiplier, stepping through the states BURST, ACC and SUM.
// ----------------------------------------------------------------------------
module clru_cost import clru_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [ACC_W-1:0]   acc,
    input  logic [TIME_W-1:0]  first_time,
    input  logic [TIME_W-1:0]  burst_time,
    input  logic [BEATS_W-1:0] beats,
    output logic               done,
    output logic [LAT_W-1:0]   lat
);

    typedef enum logic [1:0] {C_IDLE, C_BURST, C_ACC, C_SUM} cost_state_t;

    cost_state_t      state_reg;
    logic [LAT_W-1:0] prod_reg;
    logic [LAT_W-1:0] sum_reg;
    logic [LAT_W-1:0] mul_a;
    logic [LAT_W-1:0] mul_b;
    logic [LAT_W-1:0] prod;

    // Operand select for the shared multiplier
    always_comb begin
        if (state_reg == C_BURST) begin
            mul_a = {{(LAT_W-BEATS_W){1'b0}}, beats} - LAT_W'(1);
            mul_b = {{(LAT_W-TIME_W){1'b0}}, burst_time};
        end else begin
            mul_a = {{(LAT_W-ACC_W){1'b0}}, acc - ACC_W'(1)};
            mul_b = {{(LAT_W-TIME_W){1'b0}}, first_time};
        end
    end

    assign prod = mul_a * mul_b;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done      <= 1'b0;
        end else begin
            done <= 1'b0;
            case (state_reg)
                C_IDLE: begin
                    if (start) state_reg <= C_BURST;
                end
                C_BURST: begin
                    prod_reg  <= prod;
                    state_reg <= C_ACC;
                end
                C_ACC: begin
                    sum_reg   <= {{(LAT_W-TIME_W){1'b0}}, first_time} + prod_reg;
                    prod_reg  <= prod;
                    state_reg <= C_SUM;
                end
                C_SUM: begin
                    lat       <= sum_reg + prod_reg;
                    done      <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/chunk_prefix_lru_cache_top.sv
// ----------------------------------------------------------------------------
// chunk_prefix_lru_cache_top
// Index of cached files, each holding a prefix of chunks, kept in LRU order.
// ----------------------------------------------------------------------------
//  channel  | ports                                | word
//  ---------+--------------------------------------+-------------------------
//  s_       | s_valid / s_ready / s_data           | lookup or store request
//  m_       | m_valid / m_ready / m_data           | hit, stored, accesses, latency
//  cfg_     | cfg_wr_en / cfg_index / cfg_wr_data  | register write
//
//  A word passes through the accept state, a scan over all MAX_FILES slots of
//  the entry memory to find the file, the LRU file and a free slot, a decide
//  state, a read-modify-write pass over all slots of the entry memories, the
//  shared multiplier for the latency (skipped on a miss or a refused store),
//  and the load of the result register.
//  Reset clears the valid bits and counters; no clearing pass is needed.
//  s_ready is high only between words; a result waiting on m_ready does not
//  hold off the next word, only the delivery of its result.
// ----------------------------------------------------------------------------
module chunk_prefix_lru_cache_top import clru_pkg::*; #(
    parameter int MAX_FILES = MAX_FILES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_FILES);
    localparam int CNT_W = $clog2(MAX_FILES + 1);
    localparam int CAP_W = (CNT_W > FCAP_W) ? CNT_W : FCAP_W;
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(MAX_FILES);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPDATE, ST_COST, ST_DONE
    } state_t;

    // Configuration registers
    logic [CHUNK_W-1:0] pcap_reg;
    logic [FCAP_W-1:0]  fcap_reg;
    logic [CHUNK_W-1:0] fchunk_reg;
    logic [TIME_W-1:0]  ftime_reg;
    logic [TIME_W-1:0]  btime_reg;
    logic [BEATS_W-1:0] beats_reg;

    // Entry memories
    logic [FILE_W-1:0]  file_mem [MAX_FILES];
    logic [CHUNK_W-1:0] last_mem [MAX_FILES];
    logic [IDX_W-1:0]   rank_mem [MAX_FILES];
    logic [FILE_W-1:0]  file_q;
    logic [CHUNK_W-1:0] last_q;
    logic [IDX_W-1:0]   rank_q;
    logic [MAX_FILES-1:0] valid_reg;

    // Sequencer
    state_t             state_reg;
    in_word_t           in_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_issue;
    logic [IDX_W-1:0]   rd_addr;

    // Scan results
    logic               match_reg;
    logic [IDX_W-1:0]   mi_reg;
    logic [CHUNK_W-1:0] m_last_reg;
    logic [IDX_W-1:0]   m_rank_reg;
    logic               lru_ok_reg;
    logic [IDX_W-1:0]   vi_reg;
    logic [CHUNK_W-1:0] v_last_reg;
    logic [IDX_W-1:0]   v_rank_reg;
    logic               free_ok_reg;
    logic [IDX_W-1:0]   fi_reg;

    // Decision
    logic               hit_reg, stored_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               drop_reg, dec_reg, add_reg, rec_reg, ext_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [CNT_W-1:0]   fcnt_reg;
    logic [CHUNK_W-1:0] cc_reg;
    logic [LAT_W-1:0]   lat_reg;
    logic               cost_start_reg;
    logic               m_valid_reg;
    out_word_t          m_data_reg;

    logic               d_hit, d_stored, d_drop, d_dec, d_add, d_rec, d_ext;
    logic [ACC_W-1:0]   d_acc;
    logic [IDX_W-1:0]   d_slot;
    logic [CNT_W-1:0]   d_fcnt;
    logic [CHUNK_W-1:0] d_cc;

    // Update pass
    logic               upd;
    logic               is_slot, is_v, is_m;
    logic               wr_last_en;
    logic [CHUNK_W-1:0] wr_last_val;
    logic [IDX_W-1:0]   wr_rank_val;

    logic               cost_done;
    logic [LAT_W-1:0]   cost_lat;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcap_reg   <= RST_PACKET_CAP;
            fcap_reg   <= RST_FILE_CAP;
            fchunk_reg <= RST_FIRST_CHUNK;
            ftime_reg  <= RST_FIRST_TIME;
            btime_reg  <= RST_BURST_TIME;
            beats_reg  <= RST_BEATS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PACKET_CAP:  pcap_reg   <= cfg_wr_data[CHUNK_W-1:0];
                REG_FILE_CAP:    fcap_reg   <= cfg_wr_data[FCAP_W-1:0];
                REG_FIRST_CHUNK: fchunk_reg <= cfg_wr_data[CHUNK_W-1:0];
                REG_FIRST_TIME:  ftime_reg  <= cfg_wr_data[TIME_W-1:0];
                REG_BURST_TIME:  btime_reg  <= cfg_wr_data[TIME_W-1:0];
                REG_BEATS:       beats_reg  <= cfg_wr_data[BEATS_W-1:0];
                default: ;
            endcase
        end
    end

    // Entry read address runs over all slots in both passes
    assign rd_issue = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) &&
                      (cnt_reg != N_CNT);
    assign rd_addr  = cnt_reg[IDX_W-1:0];

    // Update pass: new contents of the slot read in the previous cycle
    assign upd     = (state_reg == ST_UPDATE) && rd_vld_reg;
    assign is_slot = add_reg && (rd_idx_reg == slot_reg);
    assign is_v    = (rd_idx_reg == vi_reg);
    assign is_m    = (rd_idx_reg == mi_reg);

    always_comb begin
        wr_last_en  = 1'b0;
        wr_last_val = fchunk_reg;
        if (is_slot) begin
            wr_last_en  = upd;
        end else if (ext_reg && is_m) begin
            wr_last_en  = upd;
            wr_last_val = in_reg.chunk_id;
        end else if (dec_reg && is_v) begin
            wr_last_en  = upd;
            wr_last_val = v_last_reg - CHUNK_W'(1);
        end
    end

    always_comb begin
        wr_rank_val = rank_q;
        if (is_slot || (drop_reg && is_v)) begin
            wr_rank_val = '0;
        end else if (valid_reg[rd_idx_reg]) begin
            if (drop_reg && (rank_q > v_rank_reg)) wr_rank_val = rank_q - IDX_W'(1);
            if (add_reg) wr_rank_val = wr_rank_val + IDX_W'(1);
            if (rec_reg) begin
                if (is_m) wr_rank_val = '0;
                else if (rank_q < m_rank_reg) wr_rank_val = rank_q + IDX_W'(1);
            end
        end
    end

    // Entry memories: one read port, one write port
    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            file_q <= file_mem[rd_addr];
            last_q <= last_mem[rd_addr];
            rank_q <= rank_mem[rd_addr];
        end
        if (upd && is_slot) file_mem[rd_idx_reg] <= in_reg.file_id;
        if (wr_last_en)     last_mem[rd_idx_reg] <= wr_last_val;
        if (upd)            rank_mem[rd_idx_reg] <= wr_rank_val;
    end

    // Decision from the scan results
    always_comb begin
        logic [CAP_W-1:0]   cap;
        logic [ACC_W-1:0]   ev;
        logic               ok;
        logic               trim;
        cap      = CAP_W'(fcap_reg);
        if (fcap_reg == '0) cap = CAP_W'(1);
        else if (cap > CAP_W'(MAX_FILES)) cap = CAP_W'(MAX_FILES);
        ev       = '0;
        ok       = 1'b0;
        trim     = 1'b0;
        d_hit    = 1'b0;
        d_stored = 1'b0;
        d_drop   = 1'b0;
        d_dec    = 1'b0;
        d_add    = 1'b0;
        d_rec    = 1'b0;
        d_ext    = 1'b0;
        d_acc    = '0;
        d_fcnt   = fcnt_reg;
        d_cc     = cc_reg;
        if (in_reg.req_type == REQ_LOOKUP) begin
            if (match_reg && (in_reg.chunk_id <= m_last_reg)) begin
                d_hit = 1'b1;
                d_rec = 1'b1;
                d_acc = {1'b0, m_last_reg} - {1'b0, in_reg.chunk_id} + ACC_W'(1);
            end
        end else if (in_reg.chunk_id == fchunk_reg) begin
            // new file
            ok = !match_reg;
            if (match_reg) begin
                ok = 1'b0;
            end else if (CAP_W'(fcnt_reg) >= cap) begin
                if (!lru_ok_reg) begin
                    ok = 1'b0;
                end else begin
                    if (v_last_reg >= fchunk_reg)
                        ev = {1'b0, v_last_reg} - {1'b0, fchunk_reg} + ACC_W'(1);
                    if (ev > {1'b0, cc_reg}) ev = {1'b0, cc_reg};
                    d_drop = 1'b1;
                    d_fcnt = fcnt_reg - CNT_W'(1);
                    d_cc   = cc_reg - ev[CHUNK_W-1:0];
                    d_acc  = ev;
                end
            end else if (cc_reg >= pcap_reg) begin
                ok   = lru_ok_reg;
                trim = lru_ok_reg;
            end
            if (trim) begin
                if (v_last_reg <= fchunk_reg) begin
                    d_drop = 1'b1;
                    d_fcnt = fcnt_reg - CNT_W'(1);
                end else begin
                    d_dec = 1'b1;
                end
                if (cc_reg != '0) d_cc = cc_reg - CHUNK_W'(1);
            end
            if (ok && (d_drop || free_ok_reg)) begin
                d_add    = 1'b1;
                d_stored = 1'b1;
                d_fcnt   = d_fcnt + CNT_W'(1);
                if (d_cc != '1) d_cc = d_cc + CHUNK_W'(1);
                d_acc    = d_acc + ACC_W'(1);
            end else begin
                d_acc    = '0;
            end
        end else if (match_reg &&
                     ({1'b0, in_reg.chunk_id} == {1'b0, m_last_reg} + ACC_W'(1))) begin
            // extension of an open file
            ok = 1'b1;
            if (cc_reg >= pcap_reg) begin
                ok   = lru_ok_reg && (vi_reg != mi_reg);
                trim = ok;
                d_acc = ACC_W'(1);
            end
            if (trim) begin
                if (v_last_reg <= fchunk_reg) begin
                    d_drop = 1'b1;
                    d_fcnt = fcnt_reg - CNT_W'(1);
                end else begin
                    d_dec = 1'b1;
                end
                if (cc_reg != '0) d_cc = cc_reg - CHUNK_W'(1);
            end
            if (ok) begin
                d_ext    = 1'b1;
                d_stored = 1'b1;
                if (d_cc != '1) d_cc = d_cc + CHUNK_W'(1);
                d_acc    = d_acc + ACC_W'(1);
            end else begin
                d_acc    = '0;
            end
        end
        d_slot = (free_ok_reg && (!d_drop || (fi_reg < vi_reg))) ? fi_reg : vi_reg;
    end

    // Sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            fcnt_reg       <= '0;
            cc_reg         <= '0;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            cost_start_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            cost_start_reg <= 1'b0;
            rd_vld_reg     <= rd_issue;
            rd_idx_reg     <= rd_addr;
            if (rd_issue) cnt_reg <= cnt_reg + CNT_W'(1);
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg      <= s_data;
                        cnt_reg     <= '0;
                        match_reg   <= 1'b0;
                        lru_ok_reg  <= 1'b0;
                        free_ok_reg <= 1'b0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (rd_vld_reg) begin
                        if (valid_reg[rd_idx_reg] && (file_q == in_reg.file_id) &&
                            !match_reg) begin
                            match_reg  <= 1'b1;
                            mi_reg     <= rd_idx_reg;
                            m_last_reg <= last_q;
                            m_rank_reg <= rank_q;
                        end
                        if (valid_reg[rd_idx_reg] &&
                            (!lru_ok_reg || (rank_q > v_rank_reg))) begin
                            lru_ok_reg <= 1'b1;
                            vi_reg     <= rd_idx_reg;
                            v_last_reg <= last_q;
                            v_rank_reg <= rank_q;
                        end
                        if (!valid_reg[rd_idx_reg] && !free_ok_reg) begin
                            free_ok_reg <= 1'b1;
                            fi_reg      <= rd_idx_reg;
                        end
                    end else if (cnt_reg == N_CNT) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    hit_reg    <= d_hit;
                    stored_reg <= d_stored;
                    acc_reg    <= d_acc;
                    drop_reg   <= d_drop;
                    dec_reg    <= d_dec;
                    add_reg    <= d_add;
                    rec_reg    <= d_rec;
                    ext_reg    <= d_ext;
                    slot_reg   <= d_slot;
                    fcnt_reg   <= d_fcnt;
                    cc_reg     <= d_cc;
                    cnt_reg    <= '0;
                    state_reg  <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (rd_vld_reg) begin
                        if (is_slot) valid_reg[rd_idx_reg] <= 1'b1;
                        else if (drop_reg && is_v) valid_reg[rd_idx_reg] <= 1'b0;
                    end else if (cnt_reg == N_CNT) begin
                        if (hit_reg || stored_reg) begin
                            cost_start_reg <= 1'b1;
                            state_reg      <= ST_COST;
                        end else begin
                            lat_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_COST: begin
                    if (cost_done) begin
                        lat_reg   <= cost_lat;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.hit           <= hit_reg;
                        m_data_reg.stored        <= stored_reg;
                        m_data_reg.dram_accesses <= acc_reg;
                        m_data_reg.latency       <= lat_reg;
                        m_valid_reg              <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Latency unit
    clru_cost u_cost (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cost_start_reg),
        .acc        (acc_reg),
        .first_time (ftime_reg),
        .burst_time (btime_reg),
        .beats      (beats_reg),
        .done       (cost_done),
        .lat        (cost_lat)
    );

endmodule

>>> hw/rtl/clru_check.sv
// ----------------------------------------------------------------------------
// clru_check
// Port-level checks of the cache index, bound to the top level.
// ----------------------------------------------------------------------------
`include "chunk_prefix_lru_cache_top_assert.svh"

module clru_check import clru_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // An accepted request word makes the block busy
    `CLRU_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "input ready right after an accept")

    // A stalled result word holds
    `CLRU_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")

    // A word is never both a hit and a store
    `CLRU_IMPLIES(a_hit_xor_store, m_valid, !(m_data.hit && m_data.stored), "hit and stored both set")

    // Miss or refused store charges nothing
    `CLRU_IMPLIES(a_miss_zero, m_valid && !m_data.hit && !m_data.stored, (m_data.latency == '0) && (m_data.dram_accesses == '0), "miss with nonzero cost")

    // A successful word charges at least one access
    `CLRU_IMPLIES(a_acc_nonzero, m_valid && (m_data.hit || m_data.stored), m_data.dram_accesses != '0, "hit or store with no access")

endmodule

bind chunk_prefix_lru_cache_top clru_check u_clru_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> verif/chunk_prefix_lru_cache_top_tb.sv
// ----------------------------------------------------------------------------
// chunk_prefix_lru_cache_top_tb
// Self-checking bench for the chunk-prefix LRU cache index. A directed table
// runs first, then random lookups and stores over small pools of files under
// several register settings. A behavioral copy of the index predicts every
// result word, and each delivered word is compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module chunk_prefix_lru_cache_top_tb;
    import clru_pkg::*;

    localparam int NF       = MAX_FILES_DEF;
    localparam int SETTLE   = 2 * NF + 12 + 20;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    chunk_prefix_lru_cache_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Index mirror
    bit          ix_valid [NF];
    bit [31:0]   ix_file  [NF];
    int          ix_last  [NF];
    int          ix_rank  [NF];
    int          n_files, n_chunks;
    int          pkt_cap, file_cap, first_ch;
    bit [31:0]   t_first, t_burst, beats;

    // Expected words in order: written at accept, read at delivery
    out_word_t   exp_words [2048];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          mismatches;
    int          send_idle_pct, recv_idle_pct;
    int          n_sent;
    bit          hold_req;
    int          hold_left;

    function automatic int find_file(bit [31:0] f);
        for (int i = 0; i < NF; i++)
            if (ix_valid[i] && ix_file[i] == f) return i;
        return -1;
    endfunction

    function automatic int find_lru();
        int best;
        best = -1;
        for (int i = 0; i < NF; i++)
            if (ix_valid[i] && (best < 0 || ix_rank[i] > ix_rank[best])) best = i;
        return best;
    endfunction

    function automatic void promote(int k);
        int r;
        r = ix_rank[k];
        for (int i = 0; i < NF; i++)
            if (ix_valid[i] && ix_rank[i] < r) ix_rank[i]++;
        ix_rank[k] = 0;
    endfunction

    function automatic void drop_file(int k);
        int r;
        r = ix_rank[k];
        for (int i = 0; i < NF; i++)
            if (ix_valid[i] && ix_rank[i] > r) ix_rank[i]--;
        ix_valid[k] = 1'b0;
        ix_rank[k] = 0;
        if (n_files > 0) n_files--;
    endfunction

    function automatic bit open_file(bit [31:0] f);
        int slot;
        slot = -1;
        for (int i = 0; i < NF; i++)
            if (!ix_valid[i]) begin
                slot = i;
                break;
            end
        if (slot < 0) return 1'b0;
        for (int i = 0; i < NF; i++)
            if (ix_valid[i]) ix_rank[i]++;
        ix_valid[slot] = 1'b1;
        ix_file[slot] = f;
        ix_last[slot] = first_ch;
        ix_rank[slot] = 0;
        n_files++;
        return 1'b1;
    endfunction

    // Take one chunk off the LRU file; the file goes when nothing is left
    function automatic bit trim_oldest(int keep);
        int v;
        v = find_lru();
        if (v < 0 || v == keep) return 1'b0;
        if (ix_last[v] <= first_ch) drop_file(v);
        else ix_last[v]--;
        if (n_chunks > 0) n_chunks--;
        return 1'b1;
    endfunction

    function automatic bit [31:0] access_cost(bit [31:0] acc);
        return t_first + (beats - 32'd1) * t_burst + (acc - 32'd1) * t_first;
    endfunction

    function automatic out_word_t predict_word(in_word_t w);
        out_word_t o;
        int        i, chunk, cap, v, ev;
        bit        ok;
        bit [31:0] acc;
        o = '0;
        acc = 0;
        chunk = int'(w.chunk_id);
        i = find_file(w.file_id);
        if (w.req_type == REQ_LOOKUP) begin
            if (i >= 0 && chunk <= ix_last[i]) begin
                acc = ix_last[i] - chunk + 1;
                o.hit = 1'b1;
                promote(i);
            end
        end else if (chunk == first_ch) begin
            cap = (file_cap == 0) ? 1 : (file_cap > NF ? NF : file_cap);
            ok = 1'b1;
            if (i >= 0) begin
                ok = 1'b0;
            end else if (n_files >= cap) begin
                v = find_lru();
                if (v < 0) begin
                    ok = 1'b0;
                end else begin
                    ev = (ix_last[v] >= first_ch) ? ix_last[v] - first_ch + 1 : 0;
                    if (ev > n_chunks) ev = n_chunks;
                    drop_file(v);
                    n_chunks -= ev;
                    acc += ev;
                end
            end else if (n_chunks >= pkt_cap) begin
                ok = trim_oldest(-1);
            end
            if (ok && open_file(w.file_id)) begin
                if (n_chunks < 65535) n_chunks++;
                acc += 1;
                o.stored = 1'b1;
            end else begin
                acc = 0;
            end
        end else if (i >= 0 && chunk == ix_last[i] + 1) begin
            ok = 1'b1;
            if (n_chunks >= pkt_cap) begin
                ok = trim_oldest(i);
                acc = 1;
            end
            if (ok) begin
                ix_last[i] = chunk;
                if (n_chunks < 65535) n_chunks++;
                acc += 1;
                o.stored = 1'b1;
            end else begin
                acc = 0;
            end
        end
        o.dram_accesses = acc[ACC_W-1:0];
        if (o.hit || o.stored) o.latency = access_cost(acc);
        return o;
    endfunction

    // Register write, mirrored at the same edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            REG_PACKET_CAP:  pkt_cap  = val & 32'hFFFF;
            REG_FILE_CAP:    file_cap = val & 32'h7F;
            REG_FIRST_CHUNK: first_ch = val & 32'hFFFF;
            REG_FIRST_TIME:  t_first  = val & 32'hFFFFF;
            REG_BURST_TIME:  t_burst  = val & 32'hFFFFF;
            REG_BEATS:       beats    = val & 32'h7FF;
            default: ;
        endcase
    endtask

    // Stop offering and wait for every outstanding result word
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (exp_wr != exp_rd) @(posedge aclk);
    endtask

    // Offer one word; predicted and queued at the accepting edge
    task automatic send_word(in_word_t w, bit typed, out_word_t typed_exp);
        out_word_t p;
        if (n_sent < 266)      send_idle_pct = 15;
        else if (n_sent < 533) send_idle_pct = 52;
        else                   send_idle_pct = 0;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        p = predict_word(w);
        exp_words[exp_wr[10:0]] = typed ? typed_exp : p;
        exp_wr++;
        n_sent++;
    endtask

    // Random word, mostly well-formed traffic over a pool of files
    function automatic in_word_t make_word(int pool);
        in_word_t w;
        int       r, k, last;
        r = $urandom_range(99);
        k = $urandom_range(pool - 1);
        w.file_id = 32'h5A00_0000 + k;
        k = find_file(w.file_id);
        last = (k >= 0) ? ix_last[k] : first_ch;
        if (r < 30) begin
            w.req_type = REQ_STORE;
            w.chunk_id = first_ch[15:0];
        end else if (r < 60) begin
            w.req_type = REQ_STORE;
            w.chunk_id = (k >= 0) ? 16'(last + 1) : first_ch[15:0];
        end else if (r < 85) begin
            w.req_type = REQ_LOOKUP;
            w.chunk_id = 16'(first_ch + $urandom_range(last - first_ch + 1));
        end else begin
            w.req_type = 1'($urandom);
            w.file_id  = $urandom;
            w.chunk_id = 16'($urandom);
            if ($urandom_range(1)) w.file_id[31:4] = 28'h5A00_000;
        end
        return w;
    endfunction

    // Receiver: random stalls, plus one long hold on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (exp_wr == exp_rd) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", m_data);
            end else begin
                e = exp_words[exp_rd[10:0]];
                exp_rd++;
                if (m_data.hit !== e.hit || m_data.stored !== e.stored ||
                    m_data.dram_accesses !== e.dram_accesses ||
                    m_data.latency !== e.latency) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: exp hit %0d st %0d acc %0d lat %0d, got hit %0d st %0d acc %0d lat %0d",
                                 e.hit, e.stored, e.dram_accesses, e.latency,
                                 m_data.hit, m_data.stored, m_data.dram_accesses,
                                 m_data.latency);
                end
            end
        end
    end

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t e;
    } dir_row_t;

    typedef struct {
        int unsigned pkt, fcap, first, tf, tb, bp;
        int          pool, count;
    } phase_t;

    dir_row_t dir_rows [$] = '{
        '{'{REQ_LOOKUP, 32'h0, 16'h0},          1, '{1'b0, 1'b0, 17'd0, 32'd0}},
        '{'{REQ_STORE,  32'h0, 16'h0},          1, '{1'b0, 1'b1, 17'd1, 32'd8000}},
        '{'{REQ_STORE,  32'h0, 16'h0},          1, '{1'b0, 1'b0, 17'd0, 32'd0}},
        '{'{REQ_STORE,  32'h0, 16'h1},          1, '{1'b0, 1'b1, 17'd1, 32'd8000}},
        '{'{REQ_STORE,  32'h0, 16'h3},          1, '{1'b0, 1'b0, 17'd0, 32'd0}},
        '{'{REQ_LOOKUP, 32'h0, 16'h0},          1, '{1'b1, 1'b0, 17'd2, 32'd9000}},
        '{'{REQ_LOOKUP, 32'h0, 16'h2},          1, '{1'b0, 1'b0, 17'd0, 32'd0}},
        '{'{REQ_STORE,  32'hFFFF_FFFF, 16'h0},  1, '{1'b0, 1'b1, 17'd1, 32'd8000}},
        '{'{REQ_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF}, 1, '{1'b0, 1'b0, 17'd0, 32'd0}},
        '{'{REQ_STORE,  32'hFFFF_FFFF, 16'hFFFF}, 1, '{1'b0, 1'b0, 17'd0, 32'd0}},
        '{'{REQ_LOOKUP, 32'h0, 16'h1},          0, '0},
        '{'{REQ_STORE,  32'h1234_5678, 16'h0},  0, '0},
        '{'{REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0},  0, '0}
    };

    // Register settings per phase; the first keeps the reset values
    phase_t phases [$] = '{
        '{4096, 64, 0, 1000, 1000, 8, 10, 60},
        '{12, 4, 3, 100, 10, 4, 8, 150},
        '{1, 1, 65535, 20'hFFFFF, 20'hFFFFF, 1024, 4, 100},
        '{65535, 127, 0, 0, 0, 2047, 70, 150},
        '{30, 0, 65534, 1, 1, 0, 6, 120},
        '{40, 64, 100, 777, 55, 1, 20, 220}
    };

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        pkt_cap = RST_PACKET_CAP;  file_cap = RST_FILE_CAP;
        first_ch = RST_FIRST_CHUNK; t_first = RST_FIRST_TIME;
        t_burst = RST_BURST_TIME;  beats = RST_BEATS;
        foreach (ix_valid[i]) begin
            ix_valid[i] = 1'b0;
            ix_rank[i] = 0;
        end
        n_files = 0; n_chunks = 0; mismatches = 0; n_sent = 0;
        hold_req = 1'b0; hold_left = 0; recv_idle_pct = 52;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) send_word(dir_rows[r].w, dir_rows[r].typed, dir_rows[r].e);

        foreach (phases[p]) begin
            if (p > 0) begin
                drain();
                repeat (SETTLE) @(posedge aclk);
                write_reg(REG_PACKET_CAP,  phases[p].pkt);
                write_reg(REG_FILE_CAP,    phases[p].fcap);
                write_reg(REG_FIRST_CHUNK, phases[p].first);
                write_reg(REG_FIRST_TIME,  phases[p].tf);
                write_reg(REG_BURST_TIME,  phases[p].tb);
                write_reg(REG_BEATS,       phases[p].bp);
            end
            // long receiver hold while the sender keeps offering
            if (p == 5) hold_req = 1'b1;
            for (int n = 0; n < phases[p].count; n++) begin
                if (n_sent == 266) recv_idle_pct = 15;
                if (n_sent == 533) recv_idle_pct = 0;
                // sender pause until the block is empty
                if (p == 1 && n == 75) drain();
                send_word(make_word(phases[p].pool), 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && exp_wr == exp_rd) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/clru_pkg.sv
hw/rtl/clru_cost.sv
hw/rtl/chunk_prefix_lru_cache_top.sv
hw/rtl/clru_check.sv
verif/chunk_prefix_lru_cache_top_tb.sv
